// ----- sv/dining_philosophers_arbiter_assert.svh -----
// Assertion macros shared by the arbiter RTL.
// Depends on nothing; taken in by `include in the modules that assert.
`ifndef DINING_PHILOSOPHERS_ARBITER_ASSERT_SVH
`define DINING_PHILOSOPHERS_ARBITER_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define DPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define DPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/dpa_pkg.sv -----
`timescale 1ns / 1ps
// Types and codes for the dining philosophers ring arbiter.
// No dependencies; used by the controller, datapath and top level.
package dpa_pkg;

    localparam int SEAT_W    = 4;
    localparam int MIN_W     = 5;
    localparam int PH_W      = 2;
    localparam int MIN_RESET = 5;

    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_ADD     = 2'd2,
        CMD_REMOVE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        K_GRANTED  = 3'd0,
        K_WAITING  = 3'd1,
        K_RELEASED = 3'd2,
        K_ADDED    = 3'd3,
        K_REMOVED  = 3'd4,
        K_REJECTED = 3'd5
    } t_kind;

    typedef enum logic [PH_W-1:0] {
        PH_THINKING = 2'd0,
        PH_HUNGRY   = 2'd1,
        PH_EATING   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        RD_TGT   = 2'd0,
        RD_LEFT  = 2'd1,
        RD_RIGHT = 2'd2
    } t_rd_sel;

    typedef enum logic [1:0] {
        TGT_SEAT  = 2'd0,
        TGT_LEFT  = 2'd1,
        TGT_RIGHT = 2'd2
    } t_tgt_sel;

    typedef enum logic [2:0] {
        SEL_SEAT    = 3'd0,
        SEL_ZERO    = 3'd1,
        SEL_LIVE    = 3'd2,
        SEL_LIVE_M1 = 3'd3,
        SEL_LEFT    = 3'd4,
        SEL_RIGHT   = 3'd5
    } t_seat_sel;

    typedef struct packed {
        t_cmd              command;
        logic [SEAT_W-1:0] seat;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [SEAT_W-1:0] seat_index;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic      load;
        t_rd_sel   rd_sel;
        logic      cap_t;
        logic      cap_l;
        logic      tgt_set;
        t_tgt_sel  tgt_sel;
        logic      wr_hungry;
        logic      wr_eating;
        logic      clr_seat;
        logic      emit;
        t_kind     emit_kind;
        t_seat_sel emit_sel;
        logic      emit_last;
        logic      live_inc;
        logic      live_dec;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic seat_ok;
        logic add_ok;
        logic rem_ok;
        logic grant;
        logic out_free;
    } t_dp_status;

endpackage

// ----- sv/dpa_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/dpa_dp.sv -----
`timescale 1ns / 1ps
// Datapath: request register, seat count, min_seats, phase RAM with valid bits,
// neighbor arithmetic and the result register. Depends on dpa_pkg, dpa_ram and dining_philosophers_arbiter_assert.svh.
`include "dining_philosophers_arbiter_assert.svh"
module dpa_dp import dpa_pkg::*; #(
    parameter int MAX_SEATS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_in_data,
    input  logic              i_cfg_we,
    input  logic [MIN_W-1:0]  i_cfg_wdata,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    localparam int AW = $clog2(MAX_SEATS);
    localparam int LW = $clog2(MAX_SEATS + 1);
    localparam int CW = (LW > MIN_W) ? LW : MIN_W;

    function automatic logic [LW-1:0] left_of(input logic [LW-1:0] i,
                                              input logic [LW-1:0] n);
        left_of = (i == '0) ? n - LW'(1) : i - LW'(1);
    endfunction

    function automatic logic [LW-1:0] right_of(input logic [LW-1:0] i,
                                               input logic [LW-1:0] n);
        right_of = (i + LW'(1) >= n) ? '0 : i + LW'(1);
    endfunction

    t_cmd              r_cmd;
    logic [SEAT_W-1:0] r_seat;
    logic [AW-1:0]     r_tgt;
    logic [LW-1:0]     r_live;
    logic [MIN_W-1:0]  r_min;
    logic [MAX_SEATS-1:0] r_valid;
    logic              r_rd_vld;
    t_phase            r_ph_t;
    t_phase            r_ph_l;
    logic              r_o_valid;
    t_out_item         r_o_data;

    logic [LW-1:0]     seat_lw;
    logic [LW-1:0]     tgt_lw;
    logic [LW-1:0]     live_m1;
    logic [LW-1:0]     seat_left;
    logic [LW-1:0]     seat_right;
    logic [AW-1:0]     rd_addr;
    logic [PH_W-1:0]   ram_q;
    t_phase            rd_ph;
    logic              ram_we;
    logic [PH_W-1:0]   ram_wdata;
    logic              out_free;
    logic              grant;
    logic [SEAT_W-1:0] emit_seat;

    assign seat_lw    = LW'(r_seat);
    assign tgt_lw     = LW'(r_tgt);
    assign live_m1    = r_live - LW'(1);
    assign seat_left  = left_of(seat_lw, r_live);
    assign seat_right = right_of(seat_lw, r_live);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_LEFT:  rd_addr = AW'(left_of(tgt_lw, r_live));
            RD_RIGHT: rd_addr = AW'(right_of(tgt_lw, r_live));
            default:  rd_addr = r_tgt;
        endcase
    end

    assign ram_we    = i_cmd.wr_hungry | i_cmd.wr_eating;
    assign ram_wdata = i_cmd.wr_eating ? PH_EATING : PH_HUNGRY;

    dpa_ram #(
        .WIDTH (PH_W),
        .DEPTH (MAX_SEATS)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tgt),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign rd_ph = r_rd_vld ? t_phase'(ram_q) : PH_THINKING;
    assign grant = (r_ph_t == PH_HUNGRY) && (r_ph_l != PH_EATING) && (rd_ph != PH_EATING);

    // request, target and captured phases
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_in_data.command;
            r_seat <= i_in_data.seat;
            r_tgt  <= AW'(i_in_data.seat);
        end else if (i_cmd.tgt_set) begin
            case (i_cmd.tgt_sel)
                TGT_LEFT:  r_tgt <= AW'(seat_left);
                TGT_RIGHT: r_tgt <= AW'(seat_right);
                default:   r_tgt <= AW'(r_seat);
            endcase
        end
        if (i_cmd.cap_t) begin
            r_ph_t <= rd_ph;
        end
        if (i_cmd.cap_l) begin
            r_ph_l <= rd_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_live   <= '0;
            r_min    <= MIN_W'(MIN_RESET);
        end else begin
            r_rd_vld <= r_valid[rd_addr];
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_valid[r_tgt] <= 1'b1;
            end
            if (i_cmd.clr_seat) begin
                r_valid[r_tgt] <= 1'b0;
            end
            if (i_cmd.live_inc) begin
                r_valid[r_live[AW-1:0]] <= 1'b0;
                r_live <= r_live + LW'(1);
            end
            if (i_cmd.live_dec) begin
                r_valid[live_m1[AW-1:0]] <= 1'b0;
                r_live <= live_m1;
            end
        end
    end

    always_comb begin
        case (i_cmd.emit_sel)
            SEL_ZERO:    emit_seat = '0;
            SEL_LIVE:    emit_seat = SEAT_W'(r_live);
            SEL_LIVE_M1: emit_seat = SEAT_W'(live_m1);
            SEL_LEFT:    emit_seat = SEAT_W'(seat_left);
            SEL_RIGHT:   emit_seat = SEAT_W'(seat_right);
            default:     emit_seat = r_seat;
        endcase
    end

    assign out_free = !r_o_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_data.kind       <= i_cmd.emit_kind;
            r_o_data.seat_index <= emit_seat;
            r_o_data.last       <= i_cmd.emit_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    assign o_status.cmd      = r_cmd;
    assign o_status.seat_ok  = CW'(r_seat) < CW'(r_live);
    assign o_status.add_ok   = r_live < LW'(MAX_SEATS);
    assign o_status.rem_ok   = (CW'(r_live) > CW'(r_min)) && (r_live != '0);
    assign o_status.grant    = grant;
    assign o_status.out_free = out_free;

    `DPA_ASSERT_IMPLY(a_live_bound, i_clk, i_rst_n, 1'b1, r_live <= LW'(MAX_SEATS), "seat count overflow")
    `DPA_ASSERT_IMPLY(a_emit_free, i_clk, i_rst_n, i_cmd.emit, out_free, "result dropped")
    `DPA_ASSERT_IMPLY(a_eat_grant, i_clk, i_rst_n, i_cmd.wr_eating, grant, "eating without grant")

endmodule

// ----- sv/dpa_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences decode, neighbor tests and result emission.
// Depends on dpa_pkg and dining_philosophers_arbiter_assert.svh.
`include "dining_philosophers_arbiter_assert.svh"
module dpa_ctrl import dpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DECODE   = 11'b000_0000_0010,
        S_RDT      = 11'b000_0000_0100,
        S_RDL      = 11'b000_0000_1000,
        S_RDR      = 11'b000_0001_0000,
        S_DEC      = 11'b000_0010_0000,
        S_EMIT_ONE = 11'b000_0100_0000,
        S_EMIT_REQ = 11'b000_1000_0000,
        S_EMIT_REL = 11'b001_0000_0000,
        S_EMIT_GL  = 11'b010_0000_0000,
        S_EMIT_GR  = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        MODE_REQ   = 2'd0,
        MODE_REL_L = 2'd1,
        MODE_REL_R = 2'd2
    } t_mode;

    t_state    r_state, n_state;
    t_mode     r_mode, n_mode;
    logic      r_gl, n_gl;
    logic      r_gr, n_gr;
    t_kind     r_kind, n_kind;
    t_seat_sel r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_gl    = r_gl;
        n_gr    = r_gr;
        n_kind  = r_kind;
        n_sel   = r_sel;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_gl = 1'b0;
                n_gr = 1'b0;
                case (i_status.cmd)
                    CMD_REQUEST, CMD_RELEASE: begin
                        if (!i_status.seat_ok) begin
                            n_kind  = K_REJECTED;
                            n_sel   = SEL_SEAT;
                            n_state = S_EMIT_ONE;
                        end else if (i_status.cmd == CMD_REQUEST) begin
                            o_cmd.wr_hungry = 1'b1;
                            n_mode          = MODE_REQ;
                            n_state         = S_RDT;
                        end else begin
                            o_cmd.clr_seat = 1'b1;
                            o_cmd.tgt_set  = 1'b1;
                            o_cmd.tgt_sel  = TGT_LEFT;
                            n_mode         = MODE_REL_L;
                            n_state        = S_RDT;
                        end
                    end
                    CMD_ADD: begin
                        n_kind  = i_status.add_ok ? K_ADDED : K_REJECTED;
                        n_sel   = i_status.add_ok ? SEL_LIVE : SEL_ZERO;
                        n_state = S_EMIT_ONE;
                    end
                    default: begin
                        n_kind  = i_status.rem_ok ? K_REMOVED : K_REJECTED;
                        n_sel   = i_status.rem_ok ? SEL_LIVE_M1 : SEL_ZERO;
                        n_state = S_EMIT_ONE;
                    end
                endcase
            end
            S_RDT: begin
                o_cmd.rd_sel = RD_TGT;
                n_state      = S_RDL;
            end
            S_RDL: begin
                o_cmd.rd_sel = RD_LEFT;
                o_cmd.cap_t  = 1'b1;
                n_state      = S_RDR;
            end
            S_RDR: begin
                o_cmd.rd_sel = RD_RIGHT;
                o_cmd.cap_l  = 1'b1;
                n_state      = S_DEC;
            end
            S_DEC: begin
                o_cmd.wr_eating = i_status.grant;
                case (r_mode)
                    MODE_REL_L: begin
                        n_gl          = i_status.grant;
                        o_cmd.tgt_set = 1'b1;
                        o_cmd.tgt_sel = TGT_RIGHT;
                        n_mode        = MODE_REL_R;
                        n_state       = S_RDT;
                    end
                    MODE_REL_R: begin
                        n_gr    = i_status.grant;
                        n_state = S_EMIT_REL;
                    end
                    default: begin
                        n_gl    = i_status.grant;
                        n_state = S_EMIT_REQ;
                    end
                endcase
            end
            S_EMIT_ONE: begin
                o_cmd.emit      = i_status.out_free;
                o_cmd.emit_kind = r_kind;
                o_cmd.emit_sel  = r_sel;
                o_cmd.emit_last = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.live_inc = (r_kind == K_ADDED);
                    o_cmd.live_dec = (r_kind == K_REMOVED);
                    n_state        = S_IDLE;
                end
            end
            S_EMIT_REQ: begin
                o_cmd.emit      = i_status.out_free;
                o_cmd.emit_kind = r_gl ? K_GRANTED : K_WAITING;
                o_cmd.emit_sel  = SEL_SEAT;
                o_cmd.emit_last = 1'b1;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_REL: begin
                o_cmd.emit      = i_status.out_free;
                o_cmd.emit_kind = K_RELEASED;
                o_cmd.emit_sel  = SEL_SEAT;
                o_cmd.emit_last = !(r_gl || r_gr);
                if (i_status.out_free) begin
                    n_state = r_gl ? S_EMIT_GL : (r_gr ? S_EMIT_GR : S_IDLE);
                end
            end
            S_EMIT_GL: begin
                o_cmd.emit      = i_status.out_free;
                o_cmd.emit_kind = K_GRANTED;
                o_cmd.emit_sel  = SEL_LEFT;
                o_cmd.emit_last = !r_gr;
                if (i_status.out_free) begin
                    n_state = r_gr ? S_EMIT_GR : S_IDLE;
                end
            end
            S_EMIT_GR: begin
                o_cmd.emit      = i_status.out_free;
                o_cmd.emit_kind = K_GRANTED;
                o_cmd.emit_sel  = SEL_RIGHT;
                o_cmd.emit_last = 1'b1;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_REQ;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gl   <= n_gl;
        r_gr   <= n_gr;
        r_kind <= n_kind;
        r_sel  <= n_sel;
    end

    assign o_in_stall = (r_state != S_IDLE);

    `DPA_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_cmd.emit && o_cmd.emit_last, r_state == S_IDLE, "no return to idle after last result")
    `DPA_ASSERT_IMPLY(a_add_ok, i_clk, i_rst_n, o_cmd.live_inc, i_status.add_ok, "add past full")
    `DPA_ASSERT_IMPLY(a_rem_ok, i_clk, i_rst_n, o_cmd.live_dec, i_status.rem_ok, "remove at minimum")

endmodule

// ----- sv/dining_philosophers_arbiter.sv -----
`timescale 1ns / 1ps
// Dining philosophers ring arbiter, top level. Depends on dpa_pkg, dpa_ctrl, dpa_dp.
// A new request is accepted only in idle; the input stalls until the last result of
// the previous request is written to the output register. A release gives up to three
// results, one per cycle while the output is not stalled. The phase RAM's single read
// port reads target, left and right phases in turn, one read per cycle. Synchronous
// active-low reset: all seats thinking, seat count zero, min_seats 5; no clearing pass.
module dining_philosophers_arbiter import dpa_pkg::*; #(
    parameter int MAX_SEATS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [MIN_W-1:0] i_cfg_wdata
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    dpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    dpa_dp #(
        .MAX_SEATS (MAX_SEATS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- test/dining_philosophers_arbiter_checker.sv -----
`timescale 1ns / 1ps
// Checker for the dining philosophers ring arbiter: tracks seat phases and ring size,
// predicts the results of each accepted request and compares them in order.
// Depends on dpa_pkg.
module dining_philosophers_arbiter_checker import dpa_pkg::*; #(
    parameter int MAX_SEATS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_item        i_out_data,
    input  logic             i_cfg_we,
    input  logic [MIN_W-1:0] i_cfg_wdata,
    output int               o_errors,
    output int               o_pending
);

    t_phase            phase_of [MAX_SEATS];
    logic [MIN_W-1:0]  seat_count;
    logic [MIN_W-1:0]  remove_floor;
    t_out_item         due_results[$];

    function automatic logic [SEAT_W-1:0] left_seat(input logic [SEAT_W-1:0] s);
        return (s == '0) ? SEAT_W'(seat_count - 1'b1) : s - 1'b1;
    endfunction

    function automatic logic [SEAT_W-1:0] right_seat(input logic [SEAT_W-1:0] s);
        return (({1'b0, s} + 1'b1) >= seat_count) ? '0 : s + 1'b1;
    endfunction

    function automatic bit starts_eating(input logic [SEAT_W-1:0] s);
        if (phase_of[s] == PH_HUNGRY && phase_of[left_seat(s)] != PH_EATING &&
            phase_of[right_seat(s)] != PH_EATING) begin
            phase_of[s] = PH_EATING;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_item outcome(input t_kind kind, input logic [SEAT_W-1:0] s);
        t_out_item r;
        r.kind       = kind;
        r.seat_index = s;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic arbitrate(input t_in_item req);
        t_out_item         batch[$];
        t_out_item         tail;
        logic [SEAT_W-1:0] l;
        logic [SEAT_W-1:0] r;
        case (req.command)
            CMD_REQUEST, CMD_RELEASE: begin
                if ({1'b0, req.seat} >= seat_count) begin
                    batch.push_back(outcome(K_REJECTED, req.seat));
                end else if (req.command == CMD_REQUEST) begin
                    phase_of[req.seat] = PH_HUNGRY;
                    batch.push_back(outcome(starts_eating(req.seat) ? K_GRANTED : K_WAITING,
                                            req.seat));
                end else begin
                    l = left_seat(req.seat);
                    r = right_seat(req.seat);
                    phase_of[req.seat] = PH_THINKING;
                    batch.push_back(outcome(K_RELEASED, req.seat));
                    if (starts_eating(l))
                        batch.push_back(outcome(K_GRANTED, l));
                    if (starts_eating(r))
                        batch.push_back(outcome(K_GRANTED, r));
                end
            end
            CMD_ADD: begin
                if (seat_count >= MAX_SEATS) begin
                    batch.push_back(outcome(K_REJECTED, '0));
                end else begin
                    phase_of[seat_count[SEAT_W-1:0]] = PH_THINKING;
                    batch.push_back(outcome(K_ADDED, seat_count[SEAT_W-1:0]));
                    seat_count = seat_count + 1'b1;
                end
            end
            default: begin
                if (seat_count <= remove_floor || seat_count == '0) begin
                    batch.push_back(outcome(K_REJECTED, '0));
                end else begin
                    seat_count = seat_count - 1'b1;
                    phase_of[seat_count[SEAT_W-1:0]] = PH_THINKING;
                    batch.push_back(outcome(K_REMOVED, seat_count[SEAT_W-1:0]));
                end
            end
        endcase
        tail      = batch.pop_back();
        tail.last = 1'b1;
        batch.push_back(tail);
        foreach (batch[k])
            due_results.push_back(batch[k]);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (phase_of[k])
                phase_of[k] = PH_THINKING;
            seat_count   = '0;
            remove_floor = MIN_W'(MIN_RESET);
            due_results.delete();
        end else begin
            if (i_cfg_we)
                remove_floor = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    o_errors = o_errors + 1;
                    $display("%0t: unexpected result, expected none, got kind %0d seat %0d last %0d",
                             $time, i_out_data.kind, i_out_data.seat_index, i_out_data.last);
                end else begin
                    want = due_results.pop_front();
                    if (i_out_data.kind !== want.kind ||
                        i_out_data.seat_index !== want.seat_index ||
                        i_out_data.last !== want.last) begin
                        o_errors = o_errors + 1;
                        $display("%0t: result mismatch, expected kind %0d seat %0d last %0d, got kind %0d seat %0d last %0d",
                                 $time, want.kind, want.seat_index, want.last,
                                 i_out_data.kind, i_out_data.seat_index, i_out_data.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                arbitrate(i_in_data);
        end
        o_pending = due_results.size();
    end

endmodule

// ----- test/dining_philosophers_arbiter_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the dining philosophers ring arbiter: clock, reset, request stimulus,
// min_seats writes, random stalls and the verdict. Depends on dpa_pkg, the arbiter RTL
// and dining_philosophers_arbiter_checker.
module dining_philosophers_arbiter_test;
    import dpa_pkg::*;

    localparam int MAX_SEATS      = 16;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 3000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_data;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_data;
    logic             cfg_we;
    logic [MIN_W-1:0] cfg_wdata;
    int               errors;
    int               pending;
    int               send_idle_pct = 36;
    int               recv_idle_pct = 86;
    int               live_count;
    int               floor_cfg;
    int               quiet_cycles;

    always #2 clk = ~clk;

    dining_philosophers_arbiter #(
        .MAX_SEATS   (MAX_SEATS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    dining_philosophers_arbiter_checker #(
        .MAX_SEATS   (MAX_SEATS)
    ) i_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("dining_philosophers_arbiter_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input t_cmd cmd, input logic [SEAT_W-1:0] seat);
        t_in_item req;
        req.command = cmd;
        req.seat    = seat;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd == CMD_ADD && live_count < MAX_SEATS)
            live_count++;
        else if (cmd == CMD_REMOVE && live_count > floor_cfg && live_count != 0)
            live_count--;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_floor(input int value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= MIN_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        floor_cfg = value;
    endtask

    task automatic random_requests(input int count);
        int               pick;
        t_cmd             cmd;
        logic [SEAT_W-1:0] seat;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                cmd = CMD_REQUEST;
            else if (pick < 75)
                cmd = CMD_RELEASE;
            else if (pick < 88)
                cmd = CMD_ADD;
            else
                cmd = CMD_REMOVE;
            if (live_count > 0 && $urandom_range(0, 9) != 0)
                seat = SEAT_W'($urandom_range(0, live_count - 1));
            else
                seat = SEAT_W'($urandom_range(0, 15));
            send(cmd, seat);
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        live_count = 0;
        floor_cfg  = MIN_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty ring rejects everything
        send(CMD_REMOVE, 4'd0);
        send(CMD_REQUEST, 4'd0);
        send(CMD_RELEASE, 4'd15);
        // one seat is its own neighbor
        send(CMD_ADD, 4'd9);
        send(CMD_REQUEST, 4'd0);
        send(CMD_REQUEST, 4'd0);
        send(CMD_RELEASE, 4'd0);
        // two seats: left and right coincide
        send(CMD_ADD, 4'd0);
        send(CMD_REQUEST, 4'd1);
        send(CMD_REQUEST, 4'd0);
        send(CMD_RELEASE, 4'd1);
        send(CMD_ADD, 4'd3);
        send(CMD_REQUEST, 4'd1);
        send(CMD_REQUEST, 4'd2);
        send(CMD_RELEASE, 4'd0);
        // release granting both neighbors
        send(CMD_ADD, 4'd5);
        send(CMD_REQUEST, 4'd3);
        send(CMD_RELEASE, 4'd2);
        send(CMD_RELEASE, 4'd3);
        send(CMD_RELEASE, 4'd0);
        send(CMD_REQUEST, 4'd15);
        send(CMD_REMOVE, 4'd7);
        // full ring
        while (live_count < MAX_SEATS)
            send(CMD_ADD, SEAT_W'($urandom_range(0, 15)));
        send(CMD_ADD, 4'd15);
        send(CMD_REQUEST, 4'd15);
        send(CMD_REQUEST, 4'd14);
        send(CMD_RELEASE, 4'd15);

        set_floor(16);
        send(CMD_REMOVE, 4'd0);
        set_floor(0);
        repeat (MAX_SEATS + 1) send(CMD_REMOVE, SEAT_W'($urandom_range(0, 15)));
        send(CMD_RELEASE, 4'd0);

        set_floor(2);
        random_requests(108);

        set_floor($urandom_range(0, 16));
        send_idle_pct = 86;
        recv_idle_pct = 36;
        random_requests(108);

        set_floor($urandom_range(0, 8));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_requests(107);

        settle();
        if (errors == 0)
            $display("dining_philosophers_arbiter_test: clean");
        else
            $display("dining_philosophers_arbiter_test: errors");
        $finish;
    end

endmodule
